@@ sv/pending_request_tag_table_macros.svh @@
// ----------------------------------------------------------------------------
// pending request tag table assertion macros
// shared concurrent check forms, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef PENDING_REQUEST_TAG_TABLE_MACROS_SVH
`define PENDING_REQUEST_TAG_TABLE_MACROS_SVH

// antecedent and consequent in the same cycle
`define PRTT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("prtt same-cycle check failed");

// consequent in the cycle after the antecedent
`define PRTT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("prtt next-cycle check failed");

`endif

@@ sv/prtt_pkg.sv @@
// ----------------------------------------------------------------------------
// prtt_pkg
// widths, codes and shared types of the pending request tag table
// ----------------------------------------------------------------------------
package prtt_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int REQ_W  = 2;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 4;
  localparam int PTR_W  = 32;
  localparam int SIZE_W = 32;
  localparam int STAT_W = 2;
  localparam int CODE_W = 3;

  // request types
  localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COMPLETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RETIRE   = 2'd3;

  // allocate kinds
  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MALLOC  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BARRIER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEQUEUE = 3'd4;

  // entry state codes
  localparam logic [CODE_W-1:0] ST_FREE         = 3'd0;
  localparam logic [CODE_W-1:0] ST_PEND_DATA    = 3'd1;
  localparam logic [CODE_W-1:0] ST_PEND_MALLOC  = 3'd2;
  localparam logic [CODE_W-1:0] ST_PEND_BARRIER = 3'd3;
  localparam logic [CODE_W-1:0] ST_PEND_DEQUEUE = 3'd4;
  localparam logic [CODE_W-1:0] ST_RDY_DATA     = 3'd5;
  localparam logic [CODE_W-1:0] ST_RDY_MALLOC   = 3'd6;
  localparam logic [CODE_W-1:0] ST_RDY_BARRIER  = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_READY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ERROR = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [PTR_W-1:0]  pointer;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic alloc_commit;
    logic alloc_fail;
    logic exec_commit;
    logic load_out;
  } prtt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_alloc;
    logic alloc_err;
    logic scan_free;
    logic out_free;
  } prtt_sts_t;

  function automatic logic [CODE_W-1:0] kind_to_pending(input logic [KIND_W-1:0] kind);
    logic [CODE_W-1:0] code;
    case (kind)
      KIND_CREATE, KIND_ACQUIRE: code = ST_PEND_DATA;
      KIND_MALLOC:               code = ST_PEND_MALLOC;
      KIND_BARRIER:              code = ST_PEND_BARRIER;
      default:                   code = ST_PEND_DEQUEUE;
    endcase
    return code;
  endfunction

endpackage

@@ sv/prtt_if.sv @@
// ----------------------------------------------------------------------------
// prtt channel interfaces
// valid/ready request and result channels of the pending request tag table
// ----------------------------------------------------------------------------
interface prtt_in_if import prtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [PTR_W-1:0]  resp_pointer;
  logic [SIZE_W-1:0] resp_size;

  modport source (output valid, req_type, kind, slot, resp_pointer, resp_size,
                  input ready);
  modport sink (input valid, req_type, kind, slot, resp_pointer, resp_size,
                output ready);
endinterface

interface prtt_out_if import prtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] granted_slot;
  logic [STAT_W-1:0] status;
  logic [PTR_W-1:0]  out_pointer;
  logic [SIZE_W-1:0] out_size;
  logic              size_valid;

  modport source (output valid, granted_slot, status, out_pointer, out_size, size_valid,
                  input ready);
  modport sink (input valid, granted_slot, status, out_pointer, out_size, size_valid,
                output ready);
endinterface

@@ sv/prtt_ram.sv @@
// ----------------------------------------------------------------------------
// prtt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module prtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/prtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// prtt_ctrl
// request sequencer: capture, free-slot scan or entry lookup and update, result hand-off
// ----------------------------------------------------------------------------
`include "pending_request_tag_table_macros.svh"

module prtt_ctrl import prtt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  prtt_sts_t sts,
  output prtt_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.in_alloc ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (sts.alloc_err) begin
          if (sts.out_free) begin
            cmd.alloc_fail = 1'b1;
            cmd.load_out   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.scan_free) begin
          if (sts.out_free) begin
            cmd.alloc_commit = 1'b1;
            cmd.load_out     = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec_commit = 1'b1;
          cmd.load_out    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `PRTT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
  `PRTT_ASSERT_NOW(a_load_needs_room, clk, rst_n, cmd.load_out, sts.out_free)
  `PRTT_ASSERT_NOW(a_grant_on_free, clk, rst_n, cmd.alloc_commit, sts.scan_free && !sts.alloc_err)

endmodule

@@ sv/prtt_datapath.sv @@
// ----------------------------------------------------------------------------
// prtt_datapath
// request registers, busy bits, scan pointer, entry ram and result register
// ----------------------------------------------------------------------------
`include "pending_request_tag_table_macros.svh"

module prtt_datapath import prtt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [PTR_W-1:0]  in_resp_pointer,
  input  logic [SIZE_W-1:0] in_resp_size,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_granted_slot,
  output logic [STAT_W-1:0] out_status,
  output logic [PTR_W-1:0]  out_pointer,
  output logic [SIZE_W-1:0] out_size,
  output logic              out_size_valid,
  input  prtt_cmd_t         cmd,
  output prtt_sts_t         sts
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // captured request
  logic [REQ_W-1:0]  req_type_r;
  logic [KIND_W-1:0] kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [SIZE_W-1:0] size_r;

  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [IDX_W-1:0] next_slot_r, next_slot_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] scan_inc;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_granted_r;
  logic [STAT_W-1:0] out_status_r;
  logic [PTR_W-1:0]  out_pointer_r;
  logic [SIZE_W-1:0] out_size_r;
  logic              out_svalid_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  entry_t             alloc_entry;

  logic [CODE_W-1:0] cur_code;
  logic              is_pend;
  logic              is_rdy;
  logic [STAT_W-1:0] exec_status;
  logic [PTR_W-1:0]  exec_ptr;
  logic [SIZE_W-1:0] exec_size;
  logic              exec_svalid;
  logic              exec_write;
  logic              exec_free;
  entry_t            exec_entry;

  assign slot_idx = IDX_W'(slot_r);
  assign slot_ok  = (32'(slot_r) < 32'(SLOTS));
  assign scan_inc = (scan_r == LAST_IDX) ? '0 : scan_r + 1'b1;
  assign rd_entry = entry_t'(ram_rdata);

  // entry codes, pointers and sizes; a slot with its busy bit clear is free
  prtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (IDX_W'(in_slot)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= in_req_type;
      kind_r     <= in_kind;
      slot_r     <= in_slot;
      ptr_r      <= in_resp_pointer;
      size_r     <= in_resp_size;
    end
  end

  // complete, query and retire on the entry read at capture
  always_comb begin
    cur_code    = busy_r[slot_idx] ? rd_entry.code : ST_FREE;
    is_pend     = (cur_code == ST_PEND_DATA) || (cur_code == ST_PEND_MALLOC) ||
                  (cur_code == ST_PEND_BARRIER);
    is_rdy      = (cur_code == ST_RDY_DATA) || (cur_code == ST_RDY_MALLOC) ||
                  (cur_code == ST_RDY_BARRIER);
    exec_status = STAT_ERROR;
    exec_ptr    = '0;
    exec_size   = '0;
    exec_svalid = 1'b0;
    exec_write  = 1'b0;
    exec_free   = 1'b0;
    exec_entry  = '{code: ST_RDY_DATA, pointer: ptr_r, size: size_r};
    if (cur_code == ST_PEND_MALLOC) begin
      exec_entry.code = ST_RDY_MALLOC;
    end else if (cur_code == ST_PEND_BARRIER) begin
      exec_entry.code    = ST_RDY_BARRIER;
      exec_entry.pointer = '0;
    end
    if (slot_ok) begin
      case (req_type_r)
        REQ_COMPLETE: begin
          if (is_pend) begin
            exec_status = STAT_OK;
            exec_write  = 1'b1;
          end
        end
        REQ_QUERY: begin
          if (is_pend) begin
            exec_status = STAT_BUSY;
          end else if (is_rdy) begin
            exec_status = STAT_READY;
          end
        end
        REQ_RETIRE: begin
          if (is_rdy) begin
            exec_status = STAT_OK;
            exec_ptr    = rd_entry.pointer;
            exec_free   = 1'b1;
            if (cur_code == ST_RDY_DATA) begin
              exec_size   = rd_entry.size;
              exec_svalid = 1'b1;
            end
          end else if (is_pend) begin
            exec_status = STAT_BUSY;
          end
        end
        default: begin
          exec_status = STAT_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    alloc_entry = '{code: kind_to_pending(kind_r), pointer: ptr_r, size: size_r};
    ram_we      = cmd.alloc_commit || (cmd.exec_commit && exec_write);
    ram_waddr   = cmd.alloc_commit ? scan_r : slot_idx;
    ram_wdata   = cmd.alloc_commit ? ENTRY_W'(alloc_entry) : ENTRY_W'(exec_entry);
  end

  always_comb begin
    busy_nxt      = busy_r;
    next_slot_nxt = next_slot_r;
    scan_nxt      = scan_r;
    if (cmd.alloc_commit) begin
      busy_nxt[scan_r] = 1'b1;
      next_slot_nxt    = scan_inc;
    end
    if (cmd.exec_commit && exec_free) begin
      busy_nxt[slot_idx] = 1'b0;
    end
    if (cmd.capture) begin
      scan_nxt = next_slot_r;
    end else if (cmd.scan_step) begin
      scan_nxt = scan_inc;
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      next_slot_r <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      next_slot_r <= next_slot_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.alloc_commit) begin
        out_granted_r <= SLOT_W'(scan_r);
        out_status_r  <= STAT_OK;
        out_pointer_r <= '0;
        out_size_r    <= '0;
        out_svalid_r  <= 1'b0;
      end else if (cmd.alloc_fail) begin
        out_granted_r <= '0;
        out_status_r  <= STAT_ERROR;
        out_pointer_r <= '0;
        out_size_r    <= '0;
        out_svalid_r  <= 1'b0;
      end else begin
        out_granted_r <= '0;
        out_status_r  <= exec_status;
        out_pointer_r <= exec_ptr;
        out_size_r    <= exec_size;
        out_svalid_r  <= exec_svalid;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_granted_r;
  assign out_status       = out_status_r;
  assign out_pointer      = out_pointer_r;
  assign out_size         = out_size_r;
  assign out_size_valid   = out_svalid_r;

  assign sts.in_alloc  = (in_req_type == REQ_ALLOC);
  assign sts.alloc_err = (kind_r > KIND_DEQUEUE) || (&busy_r);
  assign sts.scan_free = !busy_r[scan_r];
  assign sts.out_free  = !out_valid_r || out_ready;

  `PRTT_ASSERT_NEXT(a_grant_sets_busy, clk, rst_n, cmd.alloc_commit, busy_r[$past(scan_r)])
  `PRTT_ASSERT_NEXT(a_retire_frees, clk, rst_n, cmd.exec_commit && exec_free, !busy_r[$past(slot_idx)])

endmodule

@@ sv/pending_request_tag_table.sv @@
// query, complete and retire: entry read at capture, result loaded from the exec state
// allocate: capture, then the scan walks from the next-slot pointer to a free slot
// a new request word is taken only in idle, once the last result has been loaded
// the free-slot scan tests one busy bit per cycle, so a long busy run delays the grant
// reset: busy bits, next-slot pointer and result valid clear at once, no clearing pass
// ----------------------------------------------------------------------------
// pending_request_tag_table
// round-robin table of outstanding request tags with completion and retire
// ----------------------------------------------------------------------------
module pending_request_tag_table import prtt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  prtt_in_if.sink       in_req,
  prtt_out_if.source    out_rsp
);

  // command and status between sequencer and datapath
  prtt_cmd_t cmd;
  prtt_sts_t sts;
  logic      in_ready;

  // sequencer: idle takes a request word, then either walks the busy bits for
  // a free slot (allocate) or works on the entry fetched at capture
  prtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_req.ready = in_ready;

  // datapath: busy bit per slot marks allocated entries; the entry ram holds
  // state code, pointer and size and is only trusted where the busy bit is set
  // result word sits in an output register so the next request can start
  prtt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_req.req_type),
    .in_kind          (in_req.kind),
    .in_slot          (in_req.slot),
    .in_resp_pointer  (in_req.resp_pointer),
    .in_resp_size     (in_req.resp_size),
    .out_ready        (out_rsp.ready),
    .out_valid        (out_rsp.valid),
    .out_granted_slot (out_rsp.granted_slot),
    .out_status       (out_rsp.status),
    .out_pointer      (out_rsp.out_pointer),
    .out_size         (out_rsp.out_size),
    .out_size_valid   (out_rsp.size_valid),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
